// ----- rtl/core/cbs_pkg.sv -----
// shared types and constants of the cqi band selector
package cbs_pkg;

  // select_mode register bits: bit 1 picks robust mean, else bit 0 picks minimum
  localparam int unsigned MODE_W          = 2;
  localparam int unsigned MODE_ROBUST_BIT = 1;
  localparam int unsigned MODE_MIN_BIT    = 0;

  localparam int unsigned CQI_W  = 4;
  localparam int unsigned BAND_W = 5;
  localparam int unsigned MASK_W = 32;

  // quotient of the mean fits in CQI_W bits, so the divider runs CQI_W steps
  localparam int unsigned DIV_STEPS = CQI_W;
  localparam int unsigned DSTEP_W   = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [CQI_W-1:0] band_cqi;
    logic             band_usable;
    logic             last_band;
  } cbs_in_t;

  typedef struct packed {
    logic [BAND_W-1:0] chosen_band;
    logic [CQI_W-1:0]  chosen_cqi;
    logic [MASK_W-1:0] band_mask;
  } cbs_out_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } cbs_state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic scan_rd;
    logic finish;
  } cbs_cmd_t;

  typedef struct packed {
    logic robust;
    logic div_last;
    logic scan_last;
  } cbs_stat_t;

endpackage

// ----- rtl/core/cbs_ram.sv -----
// generic single-port-write ram with registered read
module cbs_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/cbs_ctrl.sv -----
// controller state machine of the cqi band selector
module cbs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              last_band_i,
  input  cbs_pkg::cbs_stat_t stat_i,
  output cbs_pkg::cbs_cmd_t  cmd_o,
  output logic              busy,
  output logic              result_valid_o
);

  cbs_pkg::cbs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbs_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    busy           = 1'b1;
    result_valid_o = 1'b0;
    case (state_q)
      cbs_pkg::ST_LOAD: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          if (last_band_i) begin
            state_d = stat_i.robust ? cbs_pkg::ST_DIV : cbs_pkg::ST_SCAN;
          end
        end
      end
      cbs_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = cbs_pkg::ST_SCAN;
        end
      end
      cbs_pkg::ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = cbs_pkg::ST_DRAIN;
        end
      end
      cbs_pkg::ST_DRAIN: begin
        state_d = cbs_pkg::ST_DONE;
      end
      cbs_pkg::ST_DONE: begin
        cmd_o.finish   = 1'b1;
        result_valid_o = 1'b1;
        state_d        = cbs_pkg::ST_LOAD;
      end
      default: begin
        state_d = cbs_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

// ----- rtl/core/cbs_datapath.sv -----
// band store, running sum, mean divider and search registers
module cbs_datapath #(
  parameter int unsigned MAX_BANDS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [cbs_pkg::MODE_W-1:0]         mode_i,
  input  cbs_pkg::cbs_in_t                   item_i,
  input  cbs_pkg::cbs_cmd_t                  cmd_i,
  output cbs_pkg::cbs_stat_t                 stat_o,
  output cbs_pkg::cbs_out_t                  result_o
);

  localparam int unsigned IDX_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BANDS + 1);
  localparam int unsigned SUM_W = $clog2(15 * MAX_BANDS + 1);
  localparam int unsigned DIV_W = SUM_W + CNT_W;
  localparam int unsigned EXT_W = IDX_W + cbs_pkg::BAND_W;
  localparam int unsigned UEX_W = MAX_BANDS + cbs_pkg::MASK_W;

  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [SUM_W-1:0]             sum_q, sum_d;
  logic [MAX_BANDS-1:0]         usable_q, usable_d;
  logic                         store_en;

  logic [SUM_W-1:0]             rem_q;
  logic [cbs_pkg::CQI_W-1:0]    quot_q;
  logic [cbs_pkg::DSTEP_W-1:0]  dstep_q;
  logic [DIV_W-1:0]             div_sub;
  logic                         div_ge;

  logic [IDX_W-1:0]             rd_addr_q;
  logic [IDX_W-1:0]             rd_idx_q;
  logic                         rd_vld_q;
  logic [cbs_pkg::CQI_W-1:0]    rd_cqi;
  logic [EXT_W-1:0]             idx_ext;

  logic                         any_all_q, any_use_q;
  logic [cbs_pkg::BAND_W-1:0]   ba_band_q, bu_band_q;
  logic [cbs_pkg::CQI_W-1:0]    ba_cqi_q, bu_cqi_q;
  logic [cbs_pkg::MASK_W-1:0]   mask_q;
  logic                         want_min, robust;
  logic                         beat_all, beat_use;
  logic [UEX_W-1:0]             usable_ext;

  assign robust   = mode_i[cbs_pkg::MODE_ROBUST_BIT];
  assign want_min = mode_i[cbs_pkg::MODE_MIN_BIT];

  // load side: items past the store depth are dropped
  assign store_en = cmd_i.load && (cnt_q < CNT_W'(MAX_BANDS));

  always_comb begin
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    usable_d = usable_q;
    if (store_en) begin
      cnt_d = cnt_q + 1'b1;
      sum_d = sum_q + SUM_W'(item_i.band_cqi);
      if (item_i.band_usable) begin
        usable_d[cnt_q[IDX_W-1:0]] = 1'b1;
      end
    end
    // report emptied once its result is out
    if (cmd_i.finish) begin
      cnt_d    = '0;
      sum_d    = '0;
      usable_d = '0;
    end
  end

  cbs_ram #(
    .WIDTH (cbs_pkg::CQI_W),
    .DEPTH (MAX_BANDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (item_i.band_cqi),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (rd_addr_q),
    .rdata_o (rd_cqi)
  );

  // restoring divide, one quotient bit per step
  assign div_sub = DIV_W'(cnt_q) << dstep_q;
  assign div_ge  = DIV_W'(rem_q) >= div_sub;

  assign idx_ext  = {{cbs_pkg::BAND_W{1'b0}}, rd_idx_q};
  assign beat_all = !any_all_q || (want_min ? (rd_cqi < ba_cqi_q) : (rd_cqi > ba_cqi_q));
  assign beat_use = !any_use_q || (want_min ? (rd_cqi < bu_cqi_q) : (rd_cqi > bu_cqi_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      sum_q     <= '0;
      usable_q  <= '0;
      rem_q     <= '0;
      quot_q    <= '0;
      dstep_q   <= '0;
      rd_addr_q <= '0;
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      any_all_q <= 1'b0;
      any_use_q <= 1'b0;
      ba_band_q <= '0;
      ba_cqi_q  <= '0;
      bu_band_q <= '0;
      bu_cqi_q  <= '0;
      mask_q    <= '0;
    end else begin
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
      usable_q <= usable_d;
      rd_vld_q <= cmd_i.scan_rd;

      if (cmd_i.load && item_i.last_band) begin
        rem_q     <= sum_d;
        quot_q    <= '0;
        dstep_q   <= cbs_pkg::DSTEP_W'(cbs_pkg::DIV_STEPS - 1);
        rd_addr_q <= '0;
        any_all_q <= 1'b0;
        any_use_q <= 1'b0;
        mask_q    <= '0;
      end

      if (cmd_i.div_step) begin
        if (div_ge) begin
          rem_q           <= rem_q - div_sub[SUM_W-1:0];
          quot_q[dstep_q] <= 1'b1;
        end
        dstep_q <= dstep_q - 1'b1;
      end

      if (cmd_i.scan_rd) begin
        rd_addr_q <= rd_addr_q + 1'b1;
        rd_idx_q  <= rd_addr_q;
      end

      if (rd_vld_q) begin
        if (beat_all) begin
          any_all_q <= 1'b1;
          ba_band_q <= idx_ext[cbs_pkg::BAND_W-1:0];
          ba_cqi_q  <= rd_cqi;
        end
        if (usable_q[rd_idx_q] && beat_use) begin
          any_use_q <= 1'b1;
          bu_band_q <= idx_ext[cbs_pkg::BAND_W-1:0];
          bu_cqi_q  <= rd_cqi;
        end
        if (idx_ext < EXT_W'(cbs_pkg::MASK_W)) begin
          mask_q[idx_ext[cbs_pkg::BAND_W-1:0]] <= robust ? (rd_cqi >= quot_q) : 1'b1;
        end
      end

      if (cmd_i.finish) begin
        ba_band_q <= '0;
        ba_cqi_q  <= '0;
        bu_band_q <= '0;
        bu_cqi_q  <= '0;
      end
    end
  end

  assign stat_o.robust    = robust;
  assign stat_o.div_last  = (dstep_q == '0);
  assign stat_o.scan_last = (((IDX_W + 1)'(rd_addr_q) + 1'b1) == (IDX_W + 1)'(cnt_q));

  assign usable_ext = {{cbs_pkg::MASK_W{1'b0}}, usable_q};

  always_comb begin
    if (robust) begin
      result_o.chosen_band = '0;
      result_o.chosen_cqi  = quot_q;
      result_o.band_mask   = mask_q;
    end else if (any_use_q) begin
      result_o.chosen_band = bu_band_q;
      result_o.chosen_cqi  = bu_cqi_q;
      result_o.band_mask   = usable_ext[cbs_pkg::MASK_W-1:0];
    end else begin
      result_o.chosen_band = ba_band_q;
      result_o.chosen_cqi  = ba_cqi_q;
      result_o.band_mask   = mask_q;
    end
  end

endmodule

// ----- rtl/core/cqi_band_selector.sv -----
// top level of the cqi band selector: mode register, controller and datapath
// sequence: bands load one per cycle with busy low; the band marked last ends
//   the report, and its result strobes after the store is scanned (one band
//   read from the store per cycle) and drained in maximum/minimum mode, with
//   four divider steps for the mean ahead of the scan in robust mode
// throughput: one band transaction per cycle while busy is low; busy stays high
//   from the last band until the result cycle, which the receiver always takes
// reset: asynchronous active low; mode returns to maximum, report is emptied
module cqi_band_selector #(
  parameter int unsigned MAX_BANDS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cbs_pkg::MODE_W-1:0] cfg_wdata_i,
  input  logic                       start,
  output logic                       busy,
  input  cbs_pkg::cbs_in_t           item_i,
  output logic                       result_valid_o,
  output cbs_pkg::cbs_out_t          result_o
);

  // select_mode register; the user must write it only while no report is finishing, the block does not enforce this
  logic [cbs_pkg::MODE_W-1:0] mode_q, mode_d;

  cbs_pkg::cbs_cmd_t  cmd;
  cbs_pkg::cbs_stat_t stat;

  assign mode_d = cfg_we_i ? cfg_wdata_i : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
    end else begin
      mode_q <= mode_d;
    end
  end

  // sequencer: load, divide (robust only), scan the store, drain, report
  cbs_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .last_band_i    (item_i.last_band),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  // band store, running sum, mean divider and extreme search
  cbs_datapath #(
    .MAX_BANDS (MAX_BANDS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .mode_i   (mode_q),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .result_o (result_o)
  );

  // a result transaction only shows while the block is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe while idle");

  // the last band of a report always starts the final pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.last_band) |=> (busy && !result_valid_o))
    else $error("last band did not start the final pass");

  // a band that is not last gives no result and leaves the block ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !item_i.last_band) |=> (!busy && !result_valid_o))
    else $error("non-last band produced activity");

  // one strobe per report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> (!result_valid_o && !busy))
    else $error("result strobe longer than one cycle");

  // robust mode always reports band zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && mode_q[cbs_pkg::MODE_ROBUST_BIT]) |-> (result_o.chosen_band == '0))
    else $error("robust result with nonzero band");

endmodule

// ----- verif/testbench.sv -----
// testbench for cqi_band_selector: directed and random band reports checked against a band-choice predictor
`timescale 1ns / 1ps

module testbench;

  // select_mode codes
  typedef enum logic [1:0] {
    SEL_MAX    = 2'd0,
    SEL_MIN    = 2'd1,
    SEL_ROBUST = 2'd2,
    SEL_SPARE  = 2'd3
  } sel_mode_e;

  localparam int unsigned NUM_BANDS     = 32;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 40;
  localparam int unsigned PHASE_BANDS   = 165;
  localparam int unsigned NUM_PHASES    = 8;

  logic                              clk_i       = 1'b0;
  logic                              rst_ni      = 1'b0;
  logic                              cfg_we_i    = 1'b0;
  logic [cbs_pkg::MODE_W-1:0]        cfg_wdata_i = '0;
  logic                              start       = 1'b0;
  logic                              busy;
  cbs_pkg::cbs_in_t                  item_i      = '0;
  logic                              result_valid_o;
  cbs_pkg::cbs_out_t                 result_o;

  cqi_band_selector DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow of the report being loaded and of the mode register
  logic [cbs_pkg::CQI_W-1:0] rpt_cqi [NUM_BANDS];
  logic [NUM_BANDS-1:0]      rpt_usable = '0;
  int unsigned               rpt_count  = 0;
  logic [8:0]                rpt_sum    = '0;
  sel_mode_e                 cur_mode   = SEL_MAX;

  // choices still owed by the block, oldest first
  cbs_pkg::cbs_out_t expected_choices [$];

  int unsigned failures      = 0;
  int unsigned bands_sent    = 0;
  int unsigned choices_seen  = 0;
  int unsigned dropped_bands = 0;
  int unsigned report_count [4] = '{0, 0, 0, 0};
  int unsigned burst_left    = 0;
  int unsigned stall_cycles  = 0;

  function automatic bit beats(input logic [cbs_pkg::CQI_W-1:0] cand,
                               input logic [cbs_pkg::CQI_W-1:0] cur,
                               input bit want_min);
    return want_min ? (cand < cur) : (cand > cur);
  endfunction

  // fold one accepted band into the shadow report; the last band yields a choice
  task automatic predict_choice(input cbs_pkg::cbs_in_t b);
    cbs_pkg::cbs_out_t         res;
    logic [cbs_pkg::CQI_W-1:0] mean;
    logic [cbs_pkg::CQI_W-1:0] best_c;
    logic [cbs_pkg::CQI_W-1:0] best_uc;
    int unsigned               best_b;
    int unsigned               best_ub;
    bit                        any_u;
    bit                        want_min;
    if (rpt_count < NUM_BANDS) begin
      rpt_cqi[rpt_count] = b.band_cqi;
      if (b.band_usable) rpt_usable[rpt_count] = 1'b1;
      rpt_sum   = rpt_sum + b.band_cqi;
      rpt_count = rpt_count + 1;
    end else begin
      // report too long: band is dropped
      dropped_bands++;
    end
    if (!b.last_band) return;

    res = '0;
    if (cur_mode[cbs_pkg::MODE_ROBUST_BIT]) begin
      // truncated mean, every band at or above it is in the mask
      mean = (rpt_count != 0) ? 4'(rpt_sum / rpt_count) : '0;
      for (int unsigned k = 0; k < rpt_count; k++)
        if (rpt_cqi[k] >= mean) res.band_mask[k] = 1'b1;
      res.chosen_band = '0;
      res.chosen_cqi  = mean;
    end else begin
      want_min = cur_mode[cbs_pkg::MODE_MIN_BIT];
      best_b   = 0;
      best_c   = '0;
      best_ub  = 0;
      best_uc  = '0;
      any_u    = 1'b0;
      // strict compare keeps the earliest band on a tie
      for (int unsigned k = 0; k < rpt_count; k++) begin
        if (k == 0 || beats(rpt_cqi[k], best_c, want_min)) begin
          best_b = k;
          best_c = rpt_cqi[k];
        end
        if (rpt_usable[k] && (!any_u || beats(rpt_cqi[k], best_uc, want_min))) begin
          best_ub = k;
          best_uc = rpt_cqi[k];
          any_u   = 1'b1;
        end
      end
      if (any_u) begin
        res.chosen_band = best_ub[cbs_pkg::BAND_W-1:0];
        res.chosen_cqi  = best_uc;
        res.band_mask   = rpt_usable;
      end else begin
        // nothing usable: search falls back to every loaded band
        res.chosen_band = best_b[cbs_pkg::BAND_W-1:0];
        res.chosen_cqi  = best_c;
        for (int unsigned k = 0; k < rpt_count; k++) res.band_mask[k] = 1'b1;
      end
    end
    expected_choices.push_back(res);
    report_count[cur_mode]++;
    rpt_usable = '0;
    rpt_count  = 0;
    rpt_sum    = '0;
  endtask

  // one band transaction; called right after a rising edge
  task automatic send_band(input logic [cbs_pkg::CQI_W-1:0] cqi, input logic usable,
                           input logic last);
    cbs_pkg::cbs_in_t b;
    b.band_cqi    = cqi;
    b.band_usable = usable;
    b.last_band   = last;
    start  <= 1'b1;
    item_i <= b;
    do @(posedge clk_i); while (busy);
    predict_choice(b);
    bands_sent++;
    // bursts of back-to-back bands separated by random gaps
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // wait until every owed choice has come out and the block is idle
  task automatic drain_reports();
    start <= 1'b0;
    while (expected_choices.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input sel_mode_e m);
    drain_reports();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_mode    = m;
  endtask

  // random report: mostly short, some full length, a few too long
  task automatic send_random_report();
    int unsigned               len;
    int unsigned               lo;
    int unsigned               cqi_pick;
    int unsigned               use_pick;
    logic [cbs_pkg::CQI_W-1:0] c;
    logic                      u;
    len = $urandom_range(0, 99);
    if (len < 70)      len = $urandom_range(1, 8);
    else if (len < 90) len = $urandom_range(9, NUM_BANDS - 1);
    else if (len < 95) len = NUM_BANDS;
    else               len = $urandom_range(NUM_BANDS + 1, NUM_BANDS + 4);
    cqi_pick = $urandom_range(0, 99);
    use_pick = $urandom_range(0, 99);
    lo       = $urandom_range(0, 14);
    for (int unsigned k = 0; k < len; k++) begin
      // narrow ranges make ties likely, extremes hit the field limits
      if (cqi_pick < 50)      c = 4'($urandom_range(0, 15));
      else if (cqi_pick < 80) c = 4'($urandom_range(lo, lo + 1));
      else                    c = $urandom_range(0, 1) ? 4'd15 : 4'd0;
      if (use_pick < 20)      u = 1'b0;
      else if (use_pick < 40) u = 1'b1;
      else if (use_pick < 70) u = 1'($urandom_range(0, 1));
      else                    u = ($urandom_range(0, 7) == 0);
      send_band(c, u, k == len - 1);
    end
  endtask

  task automatic test_max_mode();
    write_mode(SEL_MAX);
    send_band(4'd15, 1'b1, 1'b1);
    // ties, nothing usable
    send_band(4'd3, 1'b0, 1'b0);
    send_band(4'd7, 1'b0, 1'b0);
    send_band(4'd7, 1'b0, 1'b1);
    // usable zeros win over a larger unusable band
    send_band(4'd0, 1'b1, 1'b0);
    send_band(4'd5, 1'b0, 1'b0);
    send_band(4'd0, 1'b1, 1'b1);
    // lone unusable band still lands in the mask
    send_band(4'd0, 1'b0, 1'b1);
  endtask

  task automatic test_min_mode();
    write_mode(SEL_MIN);
    send_band(4'd9, 1'b1, 1'b0);
    send_band(4'd2, 1'b1, 1'b0);
    send_band(4'd2, 1'b1, 1'b0);
    send_band(4'd12, 1'b0, 1'b1);
    send_band(4'd15, 1'b0, 1'b1);
  endtask

  task automatic test_robust_mode();
    write_mode(SEL_ROBUST);
    send_band(4'd0, 1'b1, 1'b0);
    send_band(4'd15, 1'b0, 1'b0);
    send_band(4'd7, 1'b1, 1'b0);
    send_band(4'd8, 1'b0, 1'b1);
    send_band(4'd15, 1'b1, 1'b1);
  endtask

  // unused code 3 behaves like robust
  task automatic test_spare_mode();
    write_mode(SEL_SPARE);
    send_band(4'd1, 1'b0, 1'b0);
    send_band(4'd2, 1'b1, 1'b1);
  endtask

  // bands past the store depth are dropped, the last mark still closes the report
  task automatic test_overlong_report();
    write_mode(SEL_MAX);
    for (int unsigned k = 0; k < NUM_BANDS + 2; k++)
      send_band(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), k == NUM_BANDS + 1);
    write_mode(SEL_ROBUST);
    for (int unsigned k = 0; k < NUM_BANDS + 2; k++)
      send_band(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), k == NUM_BANDS + 1);
  endtask

  task automatic test_random_reports();
    int unsigned phase_start;
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      if (p < 4) write_mode(sel_mode_e'(p));
      else       write_mode(sel_mode_e'($urandom_range(0, 3)));
      phase_start = bands_sent;
      while (bands_sent - phase_start < PHASE_BANDS) send_random_report();
    end
  endtask

  // result checker: the block cannot be stalled, so every strobe is a transaction
  always @(posedge clk_i) begin : check_choices
    cbs_pkg::cbs_out_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_choices.size() == 0) begin
        $error("result strobe with no report pending");
        failures++;
      end else begin
        want = expected_choices.pop_front();
        choices_seen++;
        if (result_o.chosen_band !== want.chosen_band) begin
          $error("chosen_band: expected %0d, got %0d", want.chosen_band, result_o.chosen_band);
          failures++;
        end
        if (result_o.chosen_cqi !== want.chosen_cqi) begin
          $error("chosen_cqi: expected %0d, got %0d", want.chosen_cqi, result_o.chosen_cqi);
          failures++;
        end
        if (result_o.band_mask !== want.band_mask) begin
          $error("band_mask: expected %08h, got %08h", want.band_mask, result_o.band_mask);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start && !busy) || result_valid_o) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles", STALL_LIMIT);
      $display("cqi_band_selector: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_max_mode();
    test_min_mode();
    test_robust_mode();
    test_spare_mode();
    test_overlong_report();
    test_random_reports();

    drain_reports();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d bands in %0d reports (max %0d, min %0d, robust %0d, code 3 %0d)",
             bands_sent, choices_seen, report_count[SEL_MAX], report_count[SEL_MIN],
             report_count[SEL_ROBUST], report_count[SEL_SPARE]);
    $display("%0d bands dropped from over-length reports, %0d check failures",
             dropped_bands, failures);
    if (failures == 0 && expected_choices.size() == 0) begin
      $display("cqi_band_selector: match");
    end else begin
      $display("cqi_band_selector: mismatch");
    end
    $finish;
  end

endmodule
